// ----- hdl/hpe_pkg.sv -----
package hpe_pkg;

   // color width actually used from each input component
   localparam int COLOR_BITS = 16;
   localparam logic [15:0] COLOR_MASK = 16'((32'd1 << COLOR_BITS) - 32'd1);

   localparam logic [16:0] ONE_Q16 = 17'd65536;

   // divider geometry: 32-bit dividend, 16-bit divisor, two bits per stage
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = 32 / DIV_STEPS;

   // register indexes on the csr port
   localparam logic [1:0] REG_BEAT_PERIOD    = 2'd0;
   localparam logic [1:0] REG_BASE_LEVEL     = 2'd1;
   localparam logic [1:0] REG_PEAK_LEVEL     = 2'd2;
   localparam logic [1:0] REG_PULSE_FRACTION = 2'd3;

   typedef struct packed {
      logic [31:0] time_ms;
      logic [7:0]  channel;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] white;
      logic [16:0] intensity;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_channel;
      logic [15:0] out_red;
      logic [15:0] out_green;
      logic [15:0] out_blue;
      logic [15:0] out_white;
   } rsp_type;

   // settings seen by the datapath
   typedef struct packed {
      logic [15:0] period;   // never zero
      logic [15:0] edge_len; // never zero
      logic [15:0] base_level;
      logic [15:0] peak_level;
   } cfg_type;

   // item data that rides alongside the dividers
   typedef struct packed {
      logic [7:0]       channel;
      logic [3:0][15:0] lo;
      logic [3:0][15:0] hi;
      logic [16:0]      inten;
   } side_type;

   // DIV_STEPS restoring steps on {partial remainder, dividend/quotient}
   function automatic logic [47:0] div_steps(input logic [47:0] rq, input logic [15:0] d);
      logic [47:0] r;
      logic [16:0] t;
      logic [16:0] s;
      r = rq;
      for (int i = 0; i < DIV_STEPS; i++) begin
         t = {r[47:32], r[31]};
         s = t - {1'b0, d};
         r = {r[46:0], 1'b0};
         if (t >= {1'b0, d}) begin
            r[47:32] = s[15:0];
            r[0] = 1'b1;
         end else begin
            r[47:32] = t[15:0];
         end
      end
      return r;
   endfunction

   function automatic logic [15:0] scale_q16(input logic [15:0] c, input logic [15:0] f);
      logic [31:0] p;
      p = c * f;
      return p[31:16];
   endfunction

endpackage

// ----- hdl/hpe_csr.sv -----
module hpe_csr
   import hpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [15:0] period_ff;
   logic [15:0] base_ff;
   logic [15:0] peak_ff;
   logic [13:0] frac_ff;
   logic [13:0] edge_ff;
   logic [13:0] edge_in;
   logic [15:0] period_eff;
   logic [29:0] edge_prod;
   logic        wr_en;
   logic [1:0]  idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[3:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 16'd1000;
         base_ff   <= 16'd6554;
         peak_ff   <= 16'd65535;
         frac_ff   <= 14'd9830;
      end else if (wr_en) begin
         case (idx)
            REG_BEAT_PERIOD:    period_ff <= csr_pwdata[15:0];
            REG_BASE_LEVEL:     base_ff   <= csr_pwdata[15:0];
            REG_PEAK_LEVEL:     peak_ff   <= csr_pwdata[15:0];
            REG_PULSE_FRACTION: frac_ff   <= csr_pwdata[13:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (idx)
         REG_BEAT_PERIOD:    csr_prdata = {16'd0, period_ff};
         REG_BASE_LEVEL:     csr_prdata = {16'd0, base_ff};
         REG_PEAK_LEVEL:     csr_prdata = {16'd0, peak_ff};
         REG_PULSE_FRACTION: csr_prdata = {18'd0, frac_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // edge length, zero period and zero edge act as one
   assign period_eff = (period_ff == 16'd0) ? 16'd1 : period_ff;
   assign edge_prod  = period_eff * frac_ff;
   assign edge_in    = (edge_prod[29:16] == 14'd0) ? 14'd1 : edge_prod[29:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= 14'd1;
      end else begin
         edge_ff <= edge_in;
      end
   end

   assign cfg.period     = period_eff;
   assign cfg.edge_len   = {2'd0, edge_ff};
   assign cfg.base_level = base_ff;
   assign cfg.peak_level = peak_ff;

endmodule

// ----- hdl/hpe_div.sv -----
module hpe_div
   import hpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [31:0] in_dividend,
   input  logic [15:0] in_divisor,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [47:0] out_rq,
   output side_type    out_side
);

   logic [47:0] rq_ff   [DIV_STAGES];
   logic        vld_ff  [DIV_STAGES];
   side_type    side_ff [DIV_STAGES];

   // valid bits of the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s < DIV_STAGES; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // two quotient bits per stage
   always_ff @(posedge clock) begin
      if (adv) begin
         rq_ff[0]   <= div_steps({16'd0, in_dividend}, in_divisor);
         side_ff[0] <= in_side;
         for (int s = 1; s < DIV_STAGES; s++) begin
            rq_ff[s]   <= div_steps(rq_ff[s-1], in_divisor);
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // remainder in the high 16 bits, quotient in the low 32 bits
   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_rq    = rq_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

// ----- hdl/hpe_mix.sv -----
module hpe_mix
   import hpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [31:0] in_quot,
   input  side_type    in_side,
   output logic        out_valid,
   output rsp_type     out_data
);

   logic [15:0] frac;
   logic [15:0] qhi;
   logic [15:0] seg;
   logic        rising;
   logic        falling;

   // stage 1: edge endpoints and distance
   logic             v1_ff;
   logic [7:0]       ch1_ff;
   logic [16:0]      in1_ff;
   logic [15:0]      f1_ff;
   logic [3:0][15:0] a1_ff;
   logic [3:0][15:0] d1_ff;
   logic [3:0]       up1_ff;
   logic [3:0][15:0] a1_in;
   logic [3:0][15:0] d1_in;
   logic [3:0]       up1_in;

   // stage 2: distance times fraction
   logic             v2_ff;
   logic [7:0]       ch2_ff;
   logic [16:0]      in2_ff;
   logic [3:0][15:0] a2_ff;
   logic [3:0][15:0] p2_ff;
   logic [3:0]       up2_ff;

   // stage 3: interpolated color
   logic             v3_ff;
   logic [7:0]       ch3_ff;
   logic [16:0]      in3_ff;
   logic [3:0][15:0] c3_ff;
   logic [3:0][15:0] c3_in;

   // stage 4: intensity scaled output register
   logic             v4_ff;
   rsp_type          out_ff;
   rsp_type          out_in;
   logic [32:0]      ip [4];

   assign frac = in_quot[15:0];
   assign qhi  = in_quot[31:16];

   // segment of the beat: (kF, (k+1)F], phase zero in the first one
   assign seg     = ((frac == 16'd0) && (qhi != 16'd0)) ? qhi - 16'd1 : qhi;
   assign rising  = (seg == 16'd0) || (seg == 16'd2);
   assign falling = (seg == 16'd1) || (seg == 16'd3);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (rising) begin
            a1_in[k] = in_side.lo[k];
            up1_in[k] = in_side.hi[k] >= in_side.lo[k];
            d1_in[k] = up1_in[k] ? in_side.hi[k] - in_side.lo[k]
                                 : in_side.lo[k] - in_side.hi[k];
         end else if (falling) begin
            a1_in[k] = in_side.hi[k];
            up1_in[k] = in_side.lo[k] >= in_side.hi[k];
            d1_in[k] = up1_in[k] ? in_side.lo[k] - in_side.hi[k]
                                 : in_side.hi[k] - in_side.lo[k];
         end else begin
            a1_in[k] = in_side.lo[k];
            up1_in[k] = 1'b1;
            d1_in[k] = 16'd0;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         c3_in[k] = up2_ff[k] ? a2_ff[k] + p2_ff[k] : a2_ff[k] - p2_ff[k];
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ip[k] = c3_ff[k] * in3_ff;
      end
      out_in.out_channel = ch3_ff;
      out_in.out_red     = ip[0][31:16];
      out_in.out_green   = ip[1][31:16];
      out_in.out_blue    = ip[2][31:16];
      out_in.out_white   = ip[3][31:16];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         ch1_ff <= in_side.channel;
         in1_ff <= in_side.inten;
         f1_ff  <= frac;
         a1_ff  <= a1_in;
         d1_ff  <= d1_in;
         up1_ff <= up1_in;
         ch2_ff <= ch1_ff;
         in2_ff <= in1_ff;
         a2_ff  <= a1_ff;
         up2_ff <= up1_ff;
         for (int k = 0; k < 4; k++) begin
            p2_ff[k] <= scale_q16(d1_ff[k], f1_ff);
         end
         ch3_ff <= ch2_ff;
         in3_ff <= in2_ff;
         c3_ff  <= c3_in;
         out_ff <= out_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = out_ff;

endmodule

// ----- hdl/heartbeat_pulse_envelope.sv -----
// channel  direction  transfer when
// req_*    in         req_valid & req_ready, payload req_data
// rsp_*    out        rsp_valid & rsp_ready, payload rsp_data
// csr_*    in/out     apb write at csr_psel & csr_penable & csr_pwrite
//
// one item enters per cycle unless the output stalls. input and product
// stages feed two 16-stage dividers (phase mod period, then phase*65536 /
// edge length), then four blend stages ending in the output register.
// reset clears all valid bits; the registers take their defaults.
// a stalled output freezes the whole pipeline, nothing is dropped or repeated.
module heartbeat_pulse_envelope
   import hpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type     cfg;
   logic        adv;

   logic        v0_ff;
   req_type     in_ff;
   logic        v1_ff;
   logic [31:0] time1_ff;
   side_type    side1_ff;
   side_type    side1_in;
   logic [15:0] col [4];

   logic        d1_valid;
   logic [47:0] d1_rq;
   side_type    d1_side;

   logic        d2_valid;
   logic [47:0] d2_rq;
   side_type    d2_side;

   hpe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // whole pipeline moves unless the output register is held
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // input register and base/peak products
   assign col[0] = in_ff.red & COLOR_MASK;
   assign col[1] = in_ff.green & COLOR_MASK;
   assign col[2] = in_ff.blue & COLOR_MASK;
   assign col[3] = in_ff.white & COLOR_MASK;

   always_comb begin
      side1_in.channel = in_ff.channel;
      side1_in.inten   = (in_ff.intensity > ONE_Q16) ? ONE_Q16 : in_ff.intensity;
      for (int k = 0; k < 4; k++) begin
         side1_in.lo[k] = scale_q16(col[k], cfg.base_level);
         side1_in.hi[k] = scale_q16(col[k], cfg.peak_level);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff    <= req_data;
         time1_ff <= in_ff.time_ms;
         side1_ff <= side1_in;
      end
   end

   // phase within the beat
   hpe_div u_div_phase (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (v1_ff),
      .in_dividend (time1_ff),
      .in_divisor  (cfg.period),
      .in_side     (side1_ff),
      .out_valid   (d1_valid),
      .out_rq      (d1_rq),
      .out_side    (d1_side)
   );

   // edge index in the high half, edge fraction in the low half
   hpe_div u_div_frac (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (d1_valid),
      .in_dividend ({d1_rq[47:32], 16'd0}),
      .in_divisor  (cfg.edge_len),
      .in_side     (d1_side),
      .out_valid   (d2_valid),
      .out_rq      (d2_rq),
      .out_side    (d2_side)
   );

   hpe_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d2_valid),
      .in_quot   (d2_rq[31:0]),
      .in_side   (d2_side),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule
